// File: hw/rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [18:0] raw_pressure;
	} in_t;

	typedef struct packed {
		logic signed [15:0] temp_tenths;
		logic [17:0]        pressure_pa;
		logic               calc_error;
	} out_t;

	typedef enum logic [2:0] {
		REG_AC1       = 3'd0,
		REG_AC2       = 3'd1,
		REG_AC3       = 3'd2,
		REG_AC456     = 3'd3,
		REG_B1        = 3'd4,
		REG_B2        = 3'd5,
		REG_MCMD      = 3'd6,
		REG_OSS       = 3'd7
	} reg_idx_t;

	localparam logic signed [15:0] RST_AC1   = 16'sd408;
	localparam logic signed [15:0] RST_AC2   = -16'sd72;
	localparam logic signed [15:0] RST_AC3   = -16'sd14383;
	localparam logic [47:0]        RST_AC456 = 48'd140623671024241;
	localparam logic signed [15:0] RST_B1    = 16'sd6190;
	localparam logic signed [15:0] RST_B2    = 16'sd4;
	localparam logic [31:0]        RST_MCMD  = 32'd3724086068;
	localparam logic [1:0]         RST_OSS   = 2'd0;

	localparam logic signed [29:0] TEMP_OFFSET = 30'sd4000;
	localparam logic [15:0]        PRESS_SCALE = 16'd50000;
	localparam logic [31:0]        U_BIAS      = 32'd32768;
	localparam logic signed [13:0] K_SQ        = 14'sd3038;
	localparam logic signed [14:0] K_LIN       = -15'sd7357;
	localparam logic signed [17:0] K_OFS       = 18'sd3791;

	// Sideband that rides through the temperature divider.
	typedef struct packed {
		logic signed [16:0] x1;
		logic               neg;
		logic               err;
		logic [18:0]        up;
	} div1_side_t;

	// Sideband that rides through the pressure divider.
	typedef struct packed {
		logic signed [15:0] t;
		logic               err;
		logic               hi;
	} div2_side_t;

endpackage

`default_nettype wire

// File: hw/rtl/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_div #(
	parameter int NW = 27,
	parameter int DW = 18,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [NW-1:0]      quot,
	output logic [SW-1:0]      side_out
);

	logic          v_s   [NW];
	logic [DW-1:0] rem_s [NW-1];
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] d_s   [NW];
	logic [SW-1:0] sd_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [NW-1:0] nq_in;
		logic [DW-1:0] d_in;
		logic [SW-1:0] sd_in;
		logic          v_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign d_in   = den;
			assign sd_in  = side_in;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign d_in   = d_s[k-1];
			assign sd_in  = sd_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign trial = {rem_in, nq_in[NW-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k] <= {nq_in[NW-2:0], ge};
				d_s[k]  <= d_in;
				sd_s[k] <= sd_in;
			end
		end

		if (k < NW - 1) begin : g_rem
			logic [DW:0] diff;
			assign diff = trial - {1'b0, d_in};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				end
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quot      = nq_s[NW-1];
	assign side_out  = sd_s[NW-1];

endmodule

`default_nettype wire

// File: hw/rtl/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// The block takes one raw temperature and raw pressure transaction per clock
// when not stalled and returns temperature in 0.1 degree C and pressure in Pa.
// It has eight arithmetic stages, a 27-stage temperature divider, a 33-stage
// pressure divider and the output register. The whole pipeline stalls as one
// while a result waits at the output. Calibration registers are to be written
// only while the pipeline is empty; the user must ensure this, not the block.
`default_nettype none

module baro_temp_pressure_compensation (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire btpc_pkg::in_t    in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output btpc_pkg::out_t        out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [47:0]      cfg_data
);

	import btpc_pkg::*;

	logic signed [15:0] ac1_q, ac2_q, ac3_q, b1_q, b2_q;
	logic [47:0]        ac456_q;
	logic [31:0]        mcmd_q;
	logic [1:0]         oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q   <= RST_AC1;
			ac2_q   <= RST_AC2;
			ac3_q   <= RST_AC3;
			ac456_q <= RST_AC456;
			b1_q    <= RST_B1;
			b2_q    <= RST_B2;
			mcmd_q  <= RST_MCMD;
			oss_q   <= RST_OSS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_AC1:   ac1_q   <= cfg_data[15:0];
				REG_AC2:   ac2_q   <= cfg_data[15:0];
				REG_AC3:   ac3_q   <= cfg_data[15:0];
				REG_AC456: ac456_q <= cfg_data;
				REG_B1:    b1_q    <= cfg_data[15:0];
				REG_B2:    b2_q    <= cfg_data[15:0];
				REG_MCMD:  mcmd_q  <= cfg_data[31:0];
				REG_OSS:   oss_q   <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	logic [15:0]        ac4, ac5, ac6;
	logic signed [15:0] mc, md;
	assign ac4 = ac456_q[47:32];
	assign ac5 = ac456_q[31:16];
	assign ac6 = ac456_q[15:0];
	assign mc  = mcmd_q[31:16];
	assign md  = mcmd_q[15:0];

	logic out_valid_q;
	out_t out_data_q;
	logic adv;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Stage 1: X1 of the temperature path.
	logic signed [17:0] ut_diff;
	logic signed [34:0] ut_prod;
	logic               v_s1;
	logic signed [16:0] x1_s1;
	logic [18:0]        up_s1;

	assign ut_diff = $signed({2'b0, in_data.raw_temp}) - $signed({2'b0, ac6});
	assign ut_prod = ut_diff * $signed({1'b0, ac5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= ut_prod[31:15];
			up_s1 <= in_data.raw_pressure;
		end
	end

	logic signed [17:0] den1;
	logic signed [26:0] num1;
	logic [26:0]        num1_mag;
	logic [17:0]        den1_mag;
	div1_side_t         d1_side_in, d1_side_out;
	logic               d1_valid;
	logic [26:0]        d1_quot;

	assign den1       = 18'(x1_s1) + 18'(md);
	assign num1       = {mc, 11'b0};
	assign num1_mag   = num1[26] ? 27'(-num1) : num1;
	assign den1_mag   = den1[17] ? 18'(-den1) : den1;
	assign d1_side_in = '{x1: x1_s1, neg: num1[26] ^ den1[17], err: den1 == '0, up: up_s1};

	btpc_div #(.NW(27), .DW(18), .SW($bits(div1_side_t))) u_div_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      (num1_mag),
		.den      (den1_mag),
		.side_in  (d1_side_in),
		.out_valid(d1_valid),
		.quot     (d1_quot),
		.side_out (d1_side_out)
	);

	// Stage 2: B5, temperature and B6.
	logic signed [27:0] x2_t;
	logic signed [28:0] b5;
	logic signed [28:0] t_rnd;
	logic signed [24:0] t_full;
	logic signed [15:0] t_sat;
	logic               v_s2, err_s2;
	logic signed [15:0] t_s2;
	logic signed [29:0] b6_s2;
	logic [18:0]        up_s2;

	assign x2_t   = d1_side_out.neg ? -$signed({1'b0, d1_quot}) : $signed({1'b0, d1_quot});
	assign b5     = 29'(d1_side_out.x1) + 29'(x2_t);
	assign t_rnd  = b5 + 29'sd8;
	assign t_full = t_rnd[28:4];
	assign t_sat  = (t_full > 25'sd32767) ? 16'sh7fff :
	                (t_full < -25'sd32768) ? 16'sh8000 : t_full[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2 <= d1_side_out.err;
			t_s2   <= t_sat;
			b6_s2  <= 30'(b5) - TEMP_OFFSET;
			up_s2  <= d1_side_out.up;
		end
	end

	// Stage 3: B6 squared.
	logic signed [59:0] b6_sq;
	logic               v_s3, err_s3;
	logic signed [15:0] t_s3;
	logic signed [29:0] b6_s3;
	logic signed [19:0] sq_s3;
	logic [18:0]        up_s3;

	assign b6_sq = b6_s2 * b6_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s3 <= err_s2;
			t_s3   <= t_s2;
			b6_s3  <= b6_s2;
			sq_s3  <= b6_sq[31:12];
			up_s3  <= up_s2;
		end
	end

	// Stage 4: the four coefficient products.
	logic signed [35:0] m_b2, m_b1;
	logic signed [45:0] m_ac2, m_ac3;
	logic               v_s4, err_s4;
	logic signed [15:0] t_s4;
	logic signed [20:0] x1a_s4, x2a_s4;
	logic signed [18:0] x1b_s4;
	logic signed [15:0] x2b_s4;
	logic [18:0]        up_s4;

	assign m_b2  = b2_q * sq_s3;
	assign m_ac2 = ac2_q * b6_s3;
	assign m_ac3 = ac3_q * b6_s3;
	assign m_b1  = b1_q * sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4 <= err_s3;
			t_s4   <= t_s3;
			x1a_s4 <= m_b2[31:11];
			x2a_s4 <= m_ac2[31:11];
			x1b_s4 <= m_ac3[31:13];
			x2b_s4 <= m_b1[31:16];
			up_s4  <= up_s3;
		end
	end

	// Stage 5: B3 and the B4 operand.
	logic signed [21:0] x3a;
	logic signed [22:0] v1;
	logic signed [25:0] v2;
	logic signed [26:0] v3, v3_adj;
	logic signed [19:0] x3b_sum;
	logic signed [20:0] x3b_rnd;
	logic signed [18:0] x3b;
	logic signed [19:0] u_s;
	logic               v_s5, err_s5;
	logic signed [15:0] t_s5;
	logic signed [24:0] b3_s5;
	logic [31:0]        u_s5;
	logic [18:0]        up_s5;

	assign x3a     = 22'(x1a_s4) + 22'(x2a_s4);
	assign v1      = 23'($signed({ac1_q, 2'b0})) + 23'(x3a);
	assign v2      = 26'(v1) <<< oss_q;
	assign v3      = 27'(v2) + 27'sd2;
	assign v3_adj  = v3[26] ? v3 + 27'sd3 : v3;
	assign x3b_sum = 20'(x1b_s4) + 20'(x2b_s4);
	assign x3b_rnd = 21'(x3b_sum) + 21'sd2;
	assign x3b     = x3b_rnd[20:2];
	assign u_s     = 20'(x3b) + 20'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s5 <= err_s4;
			t_s5   <= t_s4;
			b3_s5  <= v3_adj[26:2];
			u_s5   <= 32'(u_s);
			up_s5  <= up_s4;
		end
	end

	// Stage 6: B4 and B7.
	logic [47:0] b4_prod;
	logic [31:0] up_b3;
	logic [47:0] b7_prod;
	logic [15:0] p_scale;
	logic        v_s6, err_s6;
	logic signed [15:0] t_s6;
	logic [16:0] b4_s6;
	logic [31:0] b7_s6;

	assign b4_prod = ac4 * u_s5;
	assign up_b3   = {13'b0, up_s5} - 32'(b3_s5);
	assign p_scale = PRESS_SCALE >> oss_q;
	assign b7_prod = up_b3 * p_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s6 <= err_s5;
			t_s6   <= t_s5;
			b4_s6  <= b4_prod[31:15];
			b7_s6  <= b7_prod[31:0];
		end
	end

	logic [32:0] num2;
	div2_side_t  d2_side_in, d2_side_out;
	logic        d2_valid;
	logic [32:0] d2_quot;

	assign num2       = b7_s6[31] ? {1'b0, b7_s6} : {b7_s6, 1'b0};
	assign d2_side_in = '{t: t_s6, err: err_s6 || (b4_s6 == '0), hi: b7_s6[31]};

	btpc_div #(.NW(33), .DW(17), .SW($bits(div2_side_t))) u_div_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s6),
		.num      (num2),
		.den      (b4_s6),
		.side_in  (d2_side_in),
		.out_valid(d2_valid),
		.quot     (d2_quot),
		.side_out (d2_side_out)
	);

	// Stage 7: pressure and its scaled square.
	logic [31:0]        pu;
	logic signed [23:0] p_hi;
	logic signed [47:0] p_hi_sq;
	logic               v_s7, err_s7;
	logic signed [15:0] t_s7;
	logic signed [31:0] p_s7, xs_s7;

	assign pu      = d2_side_out.hi ? {d2_quot[30:0], 1'b0} : d2_quot[31:0];
	assign p_hi    = pu[31:8];
	assign p_hi_sq = p_hi * p_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s7 <= d2_side_out.err;
			t_s7   <= d2_side_out.t;
			p_s7   <= pu;
			xs_s7  <= p_hi_sq[31:0];
		end
	end

	// Stage 8: correction products.
	logic signed [45:0] m_sq;
	logic signed [46:0] m_lin;
	logic               v_s8, err_s8;
	logic signed [15:0] t_s8;
	logic signed [31:0] p_s8;
	logic signed [15:0] c1_s8, c2_s8;

	assign m_sq  = xs_s7 * K_SQ;
	assign m_lin = p_s7 * K_LIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s8 <= err_s7;
			t_s8   <= t_s7;
			p_s8   <= p_s7;
			c1_s8  <= m_sq[31:16];
			c2_s8  <= m_lin[31:16];
		end
	end

	// Output register: final pressure, saturation and error masking.
	logic signed [17:0] corr;
	logic signed [13:0] corr_sh;
	logic signed [31:0] p_fin;
	logic [17:0]        p_sat;
	out_t               res;

	assign corr    = 18'(c1_s8) + 18'(c2_s8) + K_OFS;
	assign corr_sh = corr[17:4];
	assign p_fin   = p_s8 + 32'(corr_sh);
	assign p_sat   = p_fin[31] ? '0 : (p_fin > 32'sd262143) ? '1 : p_fin[17:0];

	always_comb begin
		res.calc_error  = err_s8;
		res.temp_tenths = err_s8 ? '0 : t_s8;
		res.pressure_pa = err_s8 ? '0 : p_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An error result carries zero fields.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.calc_error |-> out_data.temp_tenths == '0 &&
		out_data.pressure_pa == '0)
		else $error("error result with nonzero fields");

	// A result that is not taken stays at the output.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// The input side is open whenever the output register is free.
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline stalled with empty output");

	// A pipeline stall freezes the stage that feeds the output.
	a_s8_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_s8))
		else $error("last stage moved during stall");

endmodule

`default_nettype wire
